/* hw/rtl/rcp_pkg.sv */
// Package for the random cyclic permutation block: kind and register codes,
// generator constants, sequencer step codes and the multiply-unit control struct.
// No dependencies.
`timescale 1ns / 1ps

package rcp_pkg;

    localparam int VAL_W    = 15;
    localparam int IDX_W    = 15;
    localparam int LEN_W    = 16;
    localparam int SEED_W   = 32;
    localparam int GEN_W    = 48;
    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SACC_W   = 64;
    localparam int QUOT_W   = SACC_W - GEN_W;
    localparam int STEP_W   = 4;

    localparam logic [35:0]        GEN_MUL = 36'h5DEECE66D;
    localparam logic [MUL_B_W-1:0] GEN_M0  = GEN_MUL[17:0];
    localparam logic [MUL_B_W-1:0] GEN_M1  = GEN_MUL[35:18];
    localparam logic [GEN_W-1:0]   GEN_ADD = 48'h00000000000B;
    localparam logic [15:0]        GEN_LOW = 16'h330E;

    localparam logic [1:0] KIND_IDENTITY = 2'd0;
    localparam logic [1:0] KIND_SHUFFLE  = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;

    localparam logic CFG_SEED   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    localparam logic [STEP_W-1:0] STEP_G0 = 4'd0;
    localparam logic [STEP_W-1:0] STEP_G1 = 4'd1;
    localparam logic [STEP_W-1:0] STEP_G2 = 4'd2;
    localparam logic [STEP_W-1:0] STEP_G3 = 4'd3;
    localparam logic [STEP_W-1:0] STEP_G4 = 4'd4;
    localparam logic [STEP_W-1:0] STEP_S0 = 4'd5;
    localparam logic [STEP_W-1:0] STEP_S1 = 4'd6;
    localparam logic [STEP_W-1:0] STEP_S2 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_J  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_WI = 4'd9;
    localparam logic [STEP_W-1:0] STEP_WJ = 4'd10;

    typedef struct packed {
        logic              run;
        logic              seed_load;
        logic [STEP_W-1:0] step;
    } rcp_mul_ctrl_t;

endpackage

/* hw/rtl/rcp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module rcp_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/rcp_lcg_unit.sv */
// Generator state and shared 24x18 multiplier: steps the 48-bit LCG and forms
// the scaled draw (span * x) >> 48 from partial products. Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_lcg_unit
    import rcp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rcp_mul_ctrl_t       ctrl,
    input  logic [SEED_W-1:0]   seed,
    input  logic [MUL_B_W-1:0]  span,
    output logic [QUOT_W-1:0]   quot
);

    logic [GEN_W-1:0]   gen_reg;
    logic [GEN_W-1:0]   gen_next;
    logic [GEN_W-1:0]   acc_reg;
    logic [GEN_W-1:0]   acc_next;
    logic [SACC_W-1:0]  sacc_reg;
    logic [SACC_W-1:0]  sacc_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    always_comb
    begin
        case (ctrl.step)
            STEP_G0: begin mul_a = gen_reg[23:0];  mul_b = GEN_M0; end
            STEP_G1: begin mul_a = gen_reg[23:0];  mul_b = GEN_M1; end
            STEP_G2: begin mul_a = gen_reg[47:24]; mul_b = GEN_M0; end
            STEP_G3: begin mul_a = gen_reg[47:24]; mul_b = GEN_M1; end
            STEP_S0: begin mul_a = gen_reg[23:0];  mul_b = span;   end
            STEP_S1: begin mul_a = gen_reg[47:24]; mul_b = span;   end
            default: begin mul_a = gen_reg[23:0];  mul_b = span;   end
        endcase
    end

    always_comb
    begin
        gen_next  = gen_reg;
        acc_next  = acc_reg;
        sacc_next = sacc_reg;
        if (ctrl.seed_load)
        begin
            gen_next = {seed, GEN_LOW};
        end
        else if (ctrl.run)
        begin
            case (ctrl.step)
                STEP_G0: acc_next  = GEN_ADD;
                STEP_G1: acc_next  = acc_reg + GEN_W'(prod_reg);
                STEP_G2: acc_next  = acc_reg + (GEN_W'(prod_reg) << 18);
                STEP_G3: acc_next  = acc_reg + (GEN_W'(prod_reg) << 24);
                STEP_G4: gen_next  = acc_reg + (GEN_W'(prod_reg) << 42);
                STEP_S1: sacc_next = SACC_W'(prod_reg);
                STEP_S2: sacc_next = sacc_reg + (SACC_W'(prod_reg) << MUL_A_W);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= {32'd0, GEN_LOW};
        end
        else
        begin
            gen_reg <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        sacc_reg <= sacc_next;
    end

    assign quot = sacc_reg[SACC_W-1:GEN_W];

endmodule

/* hw/rtl/random_cyclic_permutation.sv */
// Top level: command sequencer for identity fill, Sattolo shuffle and entry read.
// Depends on rcp_pkg, rcp_ram and rcp_lcg_unit.
//
//   channel   | signals                          | transfer
//   ----------+----------------------------------+----------------------------
//   command   | start, busy, kind, index         | start high while busy low
//   result    | result_valid, entry_value,       | one cycle, result_valid high
//             | done_res                         |
//   config    | wr_en, wr_index, wr_data         | wr_en high
//
// Busy stays high while an identity fill, a read or a shuffle runs; a shuffle makes n-1
// swaps, each paced by the shared multiplier (six products per swap) and the single RAM
// port pair (two reads, two writes per swap); the result shows in the same cycle that
// busy drops. Kind 3, a read beyond the table and a shuffle with n below two raise no
// busy and answer in the next cycle.
// After reset the generator holds seed zero; the table is undefined until filled.
// Results cannot be stalled; each is shown for exactly one cycle.
`timescale 1ns / 1ps

module random_cyclic_permutation
    import rcp_pkg::*;
#(
    parameter int MAX_ENTRIES = 32768
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [IDX_W-1:0]  index,
    output logic              result_valid,
    output logic [VAL_W-1:0]  entry_value,
    output logic              done_res,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [SEED_W-1:0] wr_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_SHUF = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic [NW-1:0]     ctr_reg,    ctr_next;
    logic [NW-1:0]     n_reg,      n_next;
    logic [NW-1:0]     j_reg,      j_next;
    logic [VAL_W-1:0]  ai_reg,     ai_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic              valid_reg,  valid_next;
    logic              done_reg,   done_next;
    logic [VAL_W-1:0]  value_reg,  value_next;

    logic              accept;
    logic              idx_ok;
    logic [NW-1:0]     n_act;
    logic [NW:0]       j_sum;
    logic [NW-1:0]     j_fit;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;
    logic [QUOT_W-1:0] quot;
    logic [NW-1:0]     span;
    rcp_mul_ctrl_t     mul_ctrl;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign idx_ok = (32'(index) < MAX_ENTRIES);

    always_comb
    begin
        if (len_reg == '0)
        begin
            n_act = NW'(1);
        end
        else if (32'(len_reg) > MAX_ENTRIES)
        begin
            n_act = NW'(MAX_ENTRIES);
        end
        else
        begin
            n_act = NW'(len_reg);
        end
    end

    assign span  = n_reg - ctr_reg - NW'(1);
    assign j_sum = (NW+1)'(ctr_reg) + (NW+1)'(1) + (NW+1)'(quot);
    assign j_fit = (j_sum >= (NW+1)'(n_reg)) ? (n_reg - NW'(1)) : j_sum[NW-1:0];

    assign mul_ctrl.run       = (state_reg == ST_SHUF);
    assign mul_ctrl.seed_load = wr_en && (wr_index == CFG_SEED);
    assign mul_ctrl.step      = step_reg;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            ram_raddr = AW'(index);
        end
        else if (step_reg == STEP_J)
        begin
            ram_raddr = j_fit[AW-1:0];
        end
        else
        begin
            ram_raddr = ctr_reg[AW-1:0];
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ctr_reg[AW-1:0];
        ram_wdata = VAL_W'(ctr_reg);
        if (state_reg == ST_FILL)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_SHUF && step_reg == STEP_WI)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end
        else if (state_reg == ST_SHUF && step_reg == STEP_WJ)
        begin
            ram_we    = 1'b1;
            ram_waddr = j_reg[AW-1:0];
            ram_wdata = ai_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ctr_next   = ctr_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        ai_next    = ai_reg;
        len_next   = len_reg;
        valid_next = 1'b0;
        done_next  = done_reg;
        value_next = value_reg;

        if (wr_en && wr_index == CFG_LENGTH)
        begin
            len_next = wr_data[LEN_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = n_act;
                    ctr_next   = '0;
                    step_next  = STEP_G0;
                    value_next = '0;
                    done_next  = 1'b1;
                    case (kind)
                        KIND_IDENTITY: state_next = ST_FILL;
                        KIND_SHUFFLE:
                        begin
                            if (n_act >= NW'(2))
                            begin
                                state_next = ST_SHUF;
                            end
                            else
                            begin
                                valid_next = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            if (idx_ok)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next  = 1'b0;
                            valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                ctr_next = ctr_reg + NW'(1);
                if (ctr_reg == n_reg - NW'(1))
                begin
                    state_next = ST_IDLE;
                    valid_next = 1'b1;
                end
            end
            ST_READ:
            begin
                value_next = ram_rdata;
                valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SHUF:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_G1)
                begin
                    ai_next = ram_rdata;
                end
                if (step_reg == STEP_J)
                begin
                    j_next = j_fit;
                end
                if (step_reg == STEP_WJ)
                begin
                    step_next = STEP_G0;
                    ctr_next  = ctr_reg + NW'(1);
                    if ((NW+1)'(ctr_reg) + (NW+1)'(2) >= (NW+1)'(n_reg))
                    begin
                        state_next = ST_IDLE;
                        valid_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_G0;
            len_reg   <= LEN_W'(32768);
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            len_reg   <= len_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg   <= ctr_next;
        n_reg     <= n_next;
        j_reg     <= j_next;
        ai_reg    <= ai_next;
        done_reg  <= done_next;
        value_reg <= value_next;
    end

    rcp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rcp_lcg_unit u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mul_ctrl),
        .seed  (wr_data),
        .span  (MUL_B_W'(span)),
        .quot  (quot)
    );

    assign result_valid = valid_reg;
    assign entry_value  = value_reg;
    assign done_res     = done_reg;

    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (state_reg == ST_IDLE))
        else $error("result shown while sequencer busy");

    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || valid_reg))
        else $error("accepted command neither started nor answered");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHUF) |-> (step_reg <= STEP_WJ))
        else $error("shuffle step out of range");

    a_swap_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHUF && step_reg == STEP_WI) |-> (j_reg > ctr_reg && j_reg < n_reg))
        else $error("swap partner outside i+1..n-1");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (ctr_reg < n_reg))
        else $error("fill ran past active length");

endmodule
